/* src/hgc_pkg.sv */
package hgc_pkg;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPOSE = 1'b1;

    // Jamo counts and slot layout of the glyph store
    localparam int unsigned INITIAL_COUNT = 19;
    localparam int unsigned MEDIAL_COUNT  = 21;
    localparam int unsigned FINAL_COUNT   = 27;
    localparam int unsigned MEDIAL_BASE   = 152;
    localparam int unsigned FINAL_BASE    = 236;
    localparam int unsigned SLOT_COUNT    = 344;
    localparam int unsigned SLOT_W        = 9;

    // Giyeok and kieuk initials share the first medial set
    localparam logic [4:0] INI_GIYEOK = 5'd0;
    localparam logic [4:0] INI_KIEUK  = 5'd15;

    // Defaults and limits
    localparam int unsigned GLYPH_BYTES_DEF = 32;
    localparam int unsigned MAX_OUT         = 32;
    localparam logic [5:0]  CFG_RESET       = 6'd32;

    // Initial set by vowel, before the final-present adjustment
    function automatic logic [2:0] init_set_by_vowel(input logic [4:0] med);
        logic [2:0] s;
        case (med)
            5'd8, 5'd12, 5'd18:          s = 3'd1;
            5'd13, 5'd17:                s = 3'd2;
            5'd9, 5'd10, 5'd11, 5'd19:   s = 3'd3;
            5'd14, 5'd15, 5'd16:         s = 3'd4;
            default:                     s = 3'd0;
        endcase
        return s;
    endfunction

    // Initial set used when a final consonant is present
    function automatic logic [2:0] init_set_with_final(input logic [2:0] s);
        logic [2:0] r;
        case (s)
            3'd0:          r = 3'd5;
            3'd1, 3'd2:    r = 3'd6;
            default:       r = 3'd7;
        endcase
        return r;
    endfunction

    // Final set by vowel
    function automatic logic [1:0] final_set_by_vowel(input logic [4:0] med);
        logic [1:0] s;
        case (med)
            5'd4, 5'd6, 5'd11, 5'd14, 5'd16, 5'd19:      s = 2'd1;
            5'd1, 5'd3, 5'd5, 5'd7, 5'd10, 5'd15:        s = 2'd2;
            5'd8, 5'd12, 5'd13, 5'd17, 5'd18:            s = 2'd3;
            default:                                     s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

/* src/hgc_glyph_store.sv */
module hgc_glyph_store #(
    parameter  int unsigned GLYPH_BYTES = hgc_pkg::GLYPH_BYTES_DEF,
    localparam int unsigned DEPTH       = hgc_pkg::SLOT_COUNT * GLYPH_BYTES,
    localparam int unsigned ADDR_W      = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [7:0]            wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [7:0]            rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/hangul_844_glyph_composer_top.sv */
// Load transaction: written to the glyph store at the edge that accepts it.
// Compose transaction: a setup state, then per output byte one store read per
// jamo (2, or 3 with a final) in the read state and a drain state that emits the
// byte once the output is free. The single read port of the glyph store serializes the reads.
// An index error gives its one result after the setup and error states.
// Reset clears control state and sets the byte count to 32; store is not cleared.
module hangul_844_glyph_composer_top #(
    parameter int unsigned GLYPH_BYTES = hgc_pkg::GLYPH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [13:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [4:0]  initial_index,
    input  logic [4:0]  medial_index,
    input  logic [4:0]  final_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  glyph_byte,
    output logic [4:0]  byte_position,
    output logic        last_byte,
    output logic        index_error
);

    localparam int unsigned DEPTH  = hgc_pkg::SLOT_COUNT * GLYPH_BYTES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned LIMIT  =
        (GLYPH_BYTES < hgc_pkg::MAX_OUT) ? GLYPH_BYTES : hgc_pkg::MAX_OUT;
    localparam int unsigned SW     = hgc_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [5:0]    cfg_reg;
    logic [4:0]    ini_reg, med_reg, fin_reg;
    logic [SW-1:0] islot_reg, islot_next;
    logic [SW-1:0] mslot_reg, mslot_next;
    logic [SW-1:0] fslot_reg, fslot_next;
    logic          has_fin_reg, has_fin_next;
    logic [4:0]    last_m1_reg, last_m1_next;
    logic [4:0]    offset_reg, offset_next;
    logic [1:0]    part_reg, part_next;
    logic [7:0]    acc_reg, acc_next;
    logic          rd_pend_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic [4:0]    out_pos_reg, out_pos_next;
    logic          out_last_reg, out_last_next;
    logic          out_err_reg, out_err_next;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [SW-1:0]     sel_slot;
    logic [7:0]        byte_now;
    logic [1:0]        last_part;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Store write on an accepted load inside the store range
    assign wr_en   = accept && (operation == hgc_pkg::OP_LOAD)
                     && (32'(load_address) < DEPTH);
    assign wr_addr = ADDR_W'(load_address);

    // Shared address unit: slot times glyph size plus byte offset
    always_comb
    begin
        case (part_reg)
            2'd0:    sel_slot = islot_reg;
            2'd1:    sel_slot = mslot_reg;
            default: sel_slot = fslot_reg;
        endcase
    end

    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = ADDR_W'(sel_slot) * ADDR_W'(GLYPH_BYTES) + ADDR_W'(offset_reg);

    hgc_glyph_store #(
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (load_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // OR accumulator folds in each returned store byte
    assign byte_now  = acc_reg | (rd_pend_reg ? rd_data : 8'd0);
    assign last_part = has_fin_reg ? 2'd2 : 2'd1;

    // Sequencer
    always_comb
    begin
        logic [2:0] iset;
        logic [1:0] mset;
        logic [1:0] fset;
        logic [5:0] cnt;
        logic       bad;

        iset = hgc_pkg::init_set_by_vowel(med_reg);
        mset = 2'd0;
        fset = hgc_pkg::final_set_by_vowel(med_reg);
        cnt  = cfg_reg;
        bad  = (ini_reg >= 5'(hgc_pkg::INITIAL_COUNT))
               || (med_reg >= 5'(hgc_pkg::MEDIAL_COUNT))
               || (fin_reg > 5'(hgc_pkg::FINAL_COUNT));

        state_next     = state_reg;
        islot_next     = islot_reg;
        mslot_next     = mslot_reg;
        fslot_next     = fslot_reg;
        has_fin_next   = has_fin_reg;
        last_m1_next   = last_m1_reg;
        offset_next    = offset_reg;
        part_next      = part_reg;
        acc_next       = byte_now;
        out_load       = 1'b0;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == hgc_pkg::OP_COMPOSE))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // Set selection and slot numbers
                has_fin_next = (fin_reg != 5'd0);
                if (has_fin_next)
                begin
                    iset = hgc_pkg::init_set_with_final(iset);
                end
                mset = ((ini_reg == hgc_pkg::INI_GIYEOK) || (ini_reg == hgc_pkg::INI_KIEUK))
                       ? 2'd0 : 2'd1;
                if (has_fin_next)
                begin
                    mset = mset + 2'd2;
                end
                islot_next = SW'(iset) * SW'(hgc_pkg::INITIAL_COUNT) + SW'(ini_reg);
                mslot_next = SW'(hgc_pkg::MEDIAL_BASE)
                             + SW'(mset) * SW'(hgc_pkg::MEDIAL_COUNT) + SW'(med_reg);
                fslot_next = SW'(hgc_pkg::FINAL_BASE)
                             + SW'(fset) * SW'(hgc_pkg::FINAL_COUNT) + SW'(fin_reg) - SW'(1);
                // Byte count: saturate to the limit, zero means one
                if (cnt > 6'(LIMIT))
                begin
                    cnt = 6'(LIMIT);
                end
                if (cnt == 6'd0)
                begin
                    cnt = 6'd1;
                end
                last_m1_next = 5'(cnt - 6'd1);
                offset_next  = 5'd0;
                part_next    = 2'd0;
                acc_next     = 8'd0;
                state_next   = bad ? S_ERR : S_READ;
            end
            S_READ:
            begin
                if (part_reg == last_part)
                begin
                    part_next  = 2'd0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    part_next = part_reg + 2'd1;
                end
            end
            S_DRAIN:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = byte_now;
                    out_pos_next  = offset_reg;
                    out_last_next = (offset_reg == last_m1_reg);
                    out_err_next  = 1'b0;
                    acc_next      = 8'd0;
                    offset_next   = offset_reg + 5'd1;
                    state_next    = (offset_reg == last_m1_reg) ? S_IDLE : S_READ;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = 8'd0;
                    out_pos_next  = 5'd0;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= hgc_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= (state_reg == S_READ);
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ini_reg <= initial_index;
            med_reg <= medial_index;
            fin_reg <= final_index;
        end
        islot_reg    <= islot_next;
        mslot_reg    <= mslot_next;
        fslot_reg    <= fslot_next;
        has_fin_reg  <= has_fin_next;
        last_m1_reg  <= last_m1_next;
        offset_reg   <= offset_next;
        part_reg     <= part_next;
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid     = out_valid_reg;
    assign glyph_byte    = out_byte_reg;
    assign byte_position = out_pos_reg;
    assign last_byte     = out_last_reg;
    assign index_error   = out_err_reg;

    // Error result carries no bitmap and ends the compose
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && index_error) |-> (last_byte && (byte_position == 5'd0)
                                        && (glyph_byte == 8'd0)))
        else $error("index error result malformed");

    // Final-set read only when a final is present
    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ((part_reg == 2'd0) || (part_reg == 2'd1)
                                   || ((part_reg == 2'd2) && has_fin_reg)))
        else $error("jamo part out of range");

    // Byte offset stays within the glyph count
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) || (state_reg == S_DRAIN)) |-> (offset_reg <= last_m1_reg))
        else $error("byte offset past last byte");

    // Emitting the last byte returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after last byte");

    // No new transaction while a compose is in progress
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !in_ready)
        else $error("input ready during compose");

endmodule

/* dv/hangul_844_glyph_composer_checker.sv */
module hangul_844_glyph_composer_checker #(
    parameter int unsigned GLYPH_BYTES = hgc_pkg::GLYPH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        operation,
    input  logic [13:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [4:0]  initial_index,
    input  logic [4:0]  medial_index,
    input  logic [4:0]  final_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  glyph_byte,
    input  logic [4:0]  byte_position,
    input  logic        last_byte,
    input  logic        index_error,
    output int          fail_count,
    output int          outstanding,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = hgc_pkg::SLOT_COUNT * GLYPH_BYTES;
    localparam int unsigned BYTE_CAP    =
        (GLYPH_BYTES < hgc_pkg::MAX_OUT) ? GLYPH_BYTES : hgc_pkg::MAX_OUT;

    typedef struct packed {
        logic [7:0] glyph;
        logic [4:0] pos;
        logic       last;
        logic       err;
    } glyph_out_t;

    // Jamo set selection: initial set per vowel, its closed-syllable variant,
    // and the final set per vowel
    logic [2:0] vowel_ini_set [0:20] =
        '{0, 0, 0, 0, 0, 0, 0, 0, 1, 3, 3, 3, 1, 2, 4, 4, 4, 2, 1, 3, 0};
    logic [2:0] ini_set_closed [0:4] = '{5, 6, 6, 7, 7};
    logic [1:0] vowel_fin_set [0:20] =
        '{0, 2, 0, 2, 1, 2, 1, 2, 3, 0, 2, 1, 3, 3, 1, 2, 1, 3, 3, 1, 0};

    // Shadow of the font store and the byte-count register
    logic [7:0]  font_mem [0:STORE_DEPTH-1];
    logic [5:0]  bytes_in_use = hgc_pkg::CFG_RESET;

    glyph_out_t  expected_glyph_bytes [$];
    glyph_out_t  got;
    glyph_out_t  want;
    int          mismatches = 0;
    int          result_total = 0;

    function automatic logic [7:0] font_byte(input int unsigned slot,
                                             input int unsigned offset);
        int unsigned addr;
        addr = slot * GLYPH_BYTES + offset;
        return (addr < STORE_DEPTH) ? font_mem[addr] : 8'h00;
    endfunction

    // Expected bytes of one compose transaction
    task automatic predict_glyph(input logic [4:0] ini, input logic [4:0] med,
                                 input logic [4:0] fin);
        glyph_out_t  exp_byte;
        bit          closed;
        int unsigned iset, mset, islot, mslot, fslot, n, i;
        logic [7:0]  b;
        if (ini >= hgc_pkg::INITIAL_COUNT || med >= hgc_pkg::MEDIAL_COUNT
            || fin > hgc_pkg::FINAL_COUNT) begin
            exp_byte = '{glyph: 8'h00, pos: 5'd0, last: 1'b1, err: 1'b1};
            expected_glyph_bytes.push_back(exp_byte);
        end
        else begin
            closed = (fin != 5'd0);
            iset   = closed ? ini_set_closed[vowel_ini_set[med]] : vowel_ini_set[med];
            mset   = ((ini == hgc_pkg::INI_GIYEOK || ini == hgc_pkg::INI_KIEUK) ? 0 : 1)
                     + (closed ? 2 : 0);
            islot  = iset * hgc_pkg::INITIAL_COUNT + ini;
            mslot  = hgc_pkg::MEDIAL_BASE + mset * hgc_pkg::MEDIAL_COUNT + med;
            fslot  = hgc_pkg::FINAL_BASE + vowel_fin_set[med] * hgc_pkg::FINAL_COUNT
                     + fin - 1;
            // zero means one byte, large values clip at the glyph size
            n = (bytes_in_use > BYTE_CAP) ? BYTE_CAP : bytes_in_use;
            if (n == 0)
                n = 1;
            for (i = 0; i < n; i++) begin
                b = font_byte(islot, i) | font_byte(mslot, i);
                if (closed)
                    b = b | font_byte(fslot, i);
                exp_byte = '{glyph: b, pos: 5'(i), last: (i + 1 == n), err: 1'b0};
                expected_glyph_bytes.push_back(exp_byte);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input glyph_out_t w, input glyph_out_t g);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t glyph check: %s: expected byte %02h pos %0d last %b err %b,",
                     $time, what, w.glyph, w.pos, w.last, w.err,
                     " got byte %02h pos %0d last %b err %b",
                     g.glyph, g.pos, g.last, g.err);
    endtask

    // Track config and transactions, compare each result with the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            bytes_in_use = hgc_pkg::CFG_RESET;
            expected_glyph_bytes.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_wr_en)
                bytes_in_use = cfg_wr_data;

            // compare before predicting: a result never belongs to a same-edge input
            if (out_valid && out_ready) begin
                got = '{glyph: glyph_byte, pos: byte_position, last: last_byte,
                        err: index_error};
                result_total++;
                if (expected_glyph_bytes.size() == 0)
                    note_mismatch("result with nothing pending", '0, got);
                else begin
                    want = expected_glyph_bytes.pop_front();
                    if (got.glyph !== want.glyph || got.pos !== want.pos ||
                        got.last !== want.last || got.err !== want.err)
                        note_mismatch("wrong result", want, got);
                end
            end

            if (in_valid && in_ready) begin
                if (operation == hgc_pkg::OP_LOAD) begin
                    if (load_address < STORE_DEPTH)
                        font_mem[load_address] = load_data;
                end
                else
                    predict_glyph(initial_index, medial_index, final_index);
            end

            outstanding <= expected_glyph_bytes.size();
        end
        fail_count   <= mismatches;
        results_seen <= result_total;
    end

endmodule

/* dv/hangul_844_glyph_composer_top_test.sv */
module hangul_844_glyph_composer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GB            = hgc_pkg::GLYPH_BYTES_DEF;
    localparam int unsigned STORE_DEPTH   = hgc_pkg::SLOT_COUNT * GB;
    localparam int unsigned BYTE_CAP      = (GB < hgc_pkg::MAX_OUT) ? GB : hgc_pkg::MAX_OUT;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned DRAIN_CYCLES  = 150;
    localparam int unsigned PHASE_ITEMS   = 18;
    localparam int unsigned PHASES        = 5;

    typedef struct packed {
        logic [4:0] ini;
        logic [4:0] med;
        logic [4:0] fin;
    } jamo_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = hgc_pkg::OP_LOAD;
    logic [13:0] load_address = '0;
    logic [7:0]  load_data = '0;
    logic [4:0]  initial_index = '0;
    logic [4:0]  medial_index = '0;
    logic [4:0]  final_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  glyph_byte;
    logic [4:0]  byte_position;
    logic        last_byte;
    logic        index_error;

    int          fail_count;
    int          outstanding;
    int          results_seen;
    int          idle_cycles = 0;
    int          items_sent = 0;
    int          loads_sent = 0;
    int          loads_dropped = 0;
    int          composes_sent = 0;
    int          bad_composes = 0;
    int          cfg_writes = 0;
    int unsigned n_use = BYTE_CAP;  // bytes per compose under the current count
    bit          calm = 1'b1;   // no idling on either side while set

    // Store bytes loaded so far; composes only read these
    bit          written [0:STORE_DEPTH-1];
    jamo_t       used_jamo [$];

    // Byte counts per random phase; the fourth is drawn at run time
    logic [5:0]  phase_counts [0:PHASES-1] = '{0, 2, 3, 4, 1};

    always #5 clk = ~clk;

    hangul_844_glyph_composer_top #(
        .GLYPH_BYTES(hgc_pkg::GLYPH_BYTES_DEF)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .load_address (load_address),
        .load_data    (load_data),
        .initial_index(initial_index),
        .medial_index (medial_index),
        .final_index  (final_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_byte   (glyph_byte),
        .byte_position(byte_position),
        .last_byte    (last_byte),
        .index_error  (index_error)
    );

    hangul_844_glyph_composer_checker #(
        .GLYPH_BYTES(hgc_pkg::GLYPH_BYTES_DEF)
    ) glyph_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .load_address (load_address),
        .load_data    (load_data),
        .initial_index(initial_index),
        .medial_index (medial_index),
        .final_index  (final_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .glyph_byte   (glyph_byte),
        .byte_position(byte_position),
        .last_byte    (last_byte),
        .index_error  (index_error),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("hangul_844_glyph_composer_top_test: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sparse bitmaps keep the OR of two or three glyphs informative
    function automatic logic [7:0] font_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'h01 << $urandom_range(0, 7);
        if (r < 55)
            return 8'h00;
        if (r < 65)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Glyph slots that a valid compose reads
    function automatic void glyph_slots(input logic [4:0] ini, input logic [4:0] med,
                                        input logic [4:0] fin, output int unsigned islot,
                                        output int unsigned mslot, output int unsigned fslot);
        logic [2:0]  iset;
        int unsigned mset;
        iset = hgc_pkg::init_set_by_vowel(med);
        if (fin != 5'd0)
            iset = hgc_pkg::init_set_with_final(iset);
        mset = ((ini == hgc_pkg::INI_GIYEOK) || (ini == hgc_pkg::INI_KIEUK)) ? 0 : 1;
        if (fin != 5'd0)
            mset = mset + 2;
        islot = iset * hgc_pkg::INITIAL_COUNT + ini;
        mslot = hgc_pkg::MEDIAL_BASE + mset * hgc_pkg::MEDIAL_COUNT + med;
        fslot = hgc_pkg::FINAL_BASE + hgc_pkg::final_set_by_vowel(med) * hgc_pkg::FINAL_COUNT
                + fin - 1;
    endfunction

    // Result side back-pressure
    initial begin
        int hold;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            out_ready <= 1'b1;
            hold = $urandom_range(1, 24);
            repeat (hold) @(posedge clk);
            hold = calm ? 0 : pause_len();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // One input transaction, called at a rising edge
    task automatic send_txn(input logic op, input logic [13:0] addr, input logic [7:0] data,
                            input logic [4:0] ini, input logic [4:0] med,
                            input logic [4:0] fin);
        int gap;
        gap = calm ? 0 : pause_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        load_address  <= addr;
        load_data     <= data;
        initial_index <= ini;
        medial_index  <= med;
        final_index   <= fin;
        items_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_load(input logic [13:0] addr, input logic [7:0] data);
        loads_sent++;
        if (addr >= STORE_DEPTH)
            loads_dropped++;
        else
            written[addr] = 1'b1;
        send_txn(hgc_pkg::OP_LOAD, addr, data, 5'($urandom), 5'($urandom), 5'($urandom));
    endtask

    task automatic send_compose(input logic [4:0] ini, input logic [4:0] med,
                                input logic [4:0] fin);
        composes_sent++;
        if (ini >= hgc_pkg::INITIAL_COUNT || med >= hgc_pkg::MEDIAL_COUNT
            || fin > hgc_pkg::FINAL_COUNT)
            bad_composes++;
        send_txn(hgc_pkg::OP_COMPOSE, 14'($urandom), 8'($urandom), ini, med, fin);
    endtask

    task automatic load_missing(input int unsigned addr);
        if (!written[addr])
            send_load(14'(addr), font_pattern());
    endtask

    // Load every byte a valid compose will read that is still unwritten, then compose
    task automatic send_valid_compose(input logic [4:0] ini, input logic [4:0] med,
                                      input logic [4:0] fin);
        int unsigned islot, mslot, fslot, i;
        glyph_slots(ini, med, fin, islot, mslot, fslot);
        for (i = 0; i < n_use; i++) begin
            load_missing(islot * GB + i);
            load_missing(mslot * GB + i);
            if (fin != 5'd0)
                load_missing(fslot * GB + i);
        end
        send_compose(ini, med, fin);
    endtask

    // Hold the sender until every expected result is in, then let the block settle
    task automatic drain_and_settle(input int unsigned settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_byte_count(input logic [5:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
        n_use = (value > BYTE_CAP) ? BYTE_CAP : value;
        if (n_use == 0)
            n_use = 1;
    endtask

    // Random transaction: loads in and out of range, bad and valid composes
    task automatic random_txn();
        int         r;
        logic [4:0] ini, med, fin;
        jamo_t      pick;
        r = $urandom_range(0, 99);
        if (r < 20)
            send_load(14'($urandom_range(0, STORE_DEPTH - 1)), font_pattern());
        else if (r < 24)
            send_load(14'($urandom_range(STORE_DEPTH, 16383)), 8'($urandom));
        else if (r < 36) begin
            ini = 5'($urandom);
            med = 5'($urandom);
            fin = 5'($urandom);
            case ($urandom_range(0, 2))
                0:       ini = 5'($urandom_range(hgc_pkg::INITIAL_COUNT, 31));
                1:       med = 5'($urandom_range(hgc_pkg::MEDIAL_COUNT, 31));
                default: fin = 5'($urandom_range(hgc_pkg::FINAL_COUNT + 1, 31));
            endcase
            send_compose(ini, med, fin);
        end
        else begin
            // reuse an earlier syllable half the time to keep loads few
            if (used_jamo.size() > 0 && $urandom_range(0, 99) < 50) begin
                pick = used_jamo[$urandom_range(0, used_jamo.size() - 1)];
                ini  = pick.ini;
                med  = pick.med;
                fin  = pick.fin;
            end
            else begin
                if ($urandom_range(0, 99) < 30)
                    ini = $urandom_range(0, 1) ? hgc_pkg::INI_GIYEOK : hgc_pkg::INI_KIEUK;
                else
                    ini = 5'($urandom_range(0, hgc_pkg::INITIAL_COUNT - 1));
                med = 5'($urandom_range(0, hgc_pkg::MEDIAL_COUNT - 1));
                fin = ($urandom_range(0, 99) < 30) ? 5'd0
                      : 5'($urandom_range(1, hgc_pkg::FINAL_COUNT));
                pick = '{ini: ini, med: med, fin: fin};
                used_jamo.push_back(pick);
            end
            send_valid_compose(ini, med, fin);
        end
    endtask

    // Stimulus and verdict
    initial begin
        int ph;
        int phase_end;
        int mid;
        bit paused;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        calm = 1'b0;
        write_byte_count(hgc_pkg::CFG_RESET);

        // Full glyphs: the byte count at the glyph size and saturated above it
        send_valid_compose(hgc_pkg::INI_GIYEOK, 5'd0, 5'd0);
        drain_and_settle(SETTLE_CYCLES);
        write_byte_count(6'd63);
        send_compose(hgc_pkg::INI_GIYEOK, 5'd0, 5'd0);
        drain_and_settle(SETTLE_CYCLES);
        write_byte_count(6'd33);
        send_compose(hgc_pkg::INI_GIYEOK, 5'd0, 5'd0);
        drain_and_settle(SETTLE_CYCLES);
        write_byte_count(6'd1);

        // Directed: corner jamo, all medial sets, bad indices, store edges
        send_valid_compose(hgc_pkg::INI_KIEUK, 5'd20, 5'd27);
        send_valid_compose(5'd18, 5'd8, 5'd1);
        send_valid_compose(5'd1, 5'd9, 5'd0);
        send_valid_compose(5'd2, 5'd14, 5'd5);
        send_valid_compose(5'd16, 5'd13, 5'd0);
        send_valid_compose(5'd17, 5'd13, 5'd3);
        send_compose(5'd19, 5'd0, 5'd0);
        send_compose(5'd31, 5'd31, 5'd31);
        send_compose(5'd0, 5'd21, 5'd0);
        send_compose(5'd0, 5'd0, 5'd28);
        send_compose(5'd3, 5'd4, 5'd31);
        send_compose(5'd18, 5'd20, 5'd28);
        send_load(14'd0, 8'hFF);
        send_load(14'(STORE_DEPTH - 1), 8'h00);
        send_load(14'(STORE_DEPTH), 8'hA5);
        send_load(14'h3FFF, 8'h5A);
        send_load(14'((hgc_pkg::SLOT_COUNT - 1) * GB), 8'h80);
        send_valid_compose(hgc_pkg::INI_GIYEOK, 5'd0, 5'd0);
        send_valid_compose(hgc_pkg::INI_GIYEOK, 5'd8, 5'd27);
        send_valid_compose(5'd10, 5'd20, 5'd14);

        // Random phases, each under its own byte count
        for (ph = 0; ph < PHASES; ph++) begin
            drain_and_settle(SETTLE_CYCLES);
            write_byte_count((ph == 3) ? 6'($urandom_range(2, 5)) : phase_counts[ph]);
            calm      = (ph == 1);
            phase_end = items_sent + PHASE_ITEMS;
            mid       = items_sent + PHASE_ITEMS / 2;
            paused    = 1'b0;
            while (items_sent < phase_end) begin
                random_txn();
                // pause mid-phase until all results are back
                if (ph == 2 && !paused && items_sent >= mid) begin
                    drain_and_settle(0);
                    paused = 1'b1;
                end
            end
        end

        drain_and_settle(DRAIN_CYCLES);

        $display("Covered %0d font loads (%0d dropped out of range) and %0d composes",
                 loads_sent, loads_dropped, composes_sent);
        $display("(%0d with bad indices), %0d results checked over %0d byte-count writes",
                 bad_composes, results_seen, cfg_writes);
        if (fail_count == 0 && outstanding == 0)
            $display("hangul_844_glyph_composer_top_test: clean");
        else
            $display("hangul_844_glyph_composer_top_test: errors");
        $finish;
    end

endmodule

/* files.f */
src/hgc_pkg.sv
src/hgc_glyph_store.sv
src/hangul_844_glyph_composer_top.sv
dv/hangul_844_glyph_composer_checker.sv
dv/hangul_844_glyph_composer_top_test.sv
